// File: rtl/core/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the elevator SCAN stop scheduler.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Occupancy bitmap word geometry.
    localparam int MAP_W    = 32;
    localparam int MAP_BITS = 5;

    // Width of the reported floor.
    localparam int OUT_W = 11;

    // Operation codes carried in tuser.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_ARRIVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_REPORT,
        ST_SEEK,
        ST_SCAN,
        ST_MISS,
        ST_DEC
    } t_state;

    // Search request for one bitmap word.
    typedef struct packed {
        logic [MAP_W-1:0]    word;
        logic                up;
        logic                first;
        logic [MAP_BITS-1:0] lim;
    } t_find_req;

    // Search answer: nearest set bit in the scan direction.
    typedef struct packed {
        logic                found;
        logic [MAP_BITS-1:0] bit_idx;
    } t_find_rsp;

endpackage

// File: rtl/core/esc_count_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_count_ram
// Per-floor request counters, one write port and one registered read port.
// ----------------------------------------------------------------------------
module esc_count_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/esc_map_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_map_ram
// Occupancy bitmap: one bit per floor set while its count is nonzero.
// ----------------------------------------------------------------------------
module esc_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [esc_pkg::MAP_W-1:0] o_rdata,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [esc_pkg::MAP_W-1:0] i_wdata
);
    import esc_pkg::*;

    logic [MAP_W-1:0] r_mem [DEPTH];
    logic [MAP_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/esc_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_find
// Finds the nearest set bit of one bitmap word in the scan direction.
// ----------------------------------------------------------------------------
module esc_find (
    input  esc_pkg::t_find_req i_req,
    output esc_pkg::t_find_rsp o_rsp
);
    import esc_pkg::*;

    logic [MAP_W-1:0] masked;

    // On the first word only bits at or beyond the start bit take part.
    always_comb begin
        for (int i = 0; i < MAP_W; i++) begin
            if (!i_req.first) begin
                masked[i] = i_req.word[i];
            end else if (i_req.up) begin
                masked[i] = i_req.word[i] && (MAP_BITS'(i) >= i_req.lim);
            end else begin
                masked[i] = i_req.word[i] && (MAP_BITS'(i) <= i_req.lim);
            end
        end
    end

    // Lowest set bit going up, highest set bit going down.
    always_comb begin
        o_rsp.found   = |masked;
        o_rsp.bit_idx = '0;
        if (i_req.up) begin
            for (int i = MAP_W - 1; i >= 0; i--) begin
                if (masked[i]) begin
                    o_rsp.bit_idx = MAP_BITS'(i);
                end
            end
        end else begin
            for (int i = 0; i < MAP_W; i++) begin
                if (masked[i]) begin
                    o_rsp.bit_idx = MAP_BITS'(i);
                end
            end
        end
    end

endmodule

// File: rtl/core/elevator_scan_scheduler.sv
`timescale 1ns / 1ps
// Add and cancel read the counter, then write it back; query waits in the report state
// until the output register is free. Arrive scans the bitmap word by word: the bitmap
// memory read port delivers one 32-floor word per cycle, and the two scans around a
// direction reversal together touch at most one word more than the bitmap.
// One item is in work at a time. After reset the block sweeps both memories to zero
// before it accepts its first item.
// ----------------------------------------------------------------------------
// elevator_scan_scheduler
// SCAN stop scheduler: per-floor request counts in memory, an occupancy bitmap
// scanned word by word for the next stop, current floor and travel direction.
// ----------------------------------------------------------------------------
module elevator_scan_scheduler #(
    parameter int FLOORS     = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // [9:0] floor, rest zero
    input  logic [1:0]  i_s_tuser,  // [1:0] opcode
    // Result item stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata   // [10:0] current_floor, rest zero
);
    import esc_pkg::*;

    localparam int FB  = $clog2(FLOORS);
    localparam int PW  = FB + 1;
    localparam int NW  = (FLOORS + MAP_W - 1) / MAP_W;
    localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int FX  = (FB > MAP_BITS) ? FB : MAP_BITS + 1;
    localparam int NZW = $clog2(FLOORS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Bitmap word holding a floor.
    function automatic logic [AW-1:0] f_word(input logic [FB-1:0] f);
        logic [FX-1:0] x;
        x = FX'(f);
        return AW'(x[FX-1:MAP_BITS]);
    endfunction

    // Bit of a floor within its bitmap word.
    function automatic logic [MAP_BITS-1:0] f_bit(input logic [FB-1:0] f);
        logic [FX-1:0] x;
        x = FX'(f);
        return x[MAP_BITS-1:0];
    endfunction

    // Control state.
    t_state                r_state, n_state;
    logic signed [PW-1:0]  r_pos, n_pos;
    logic                  r_up, n_up;
    logic [NZW-1:0]        r_nz, n_nz;
    logic [FB-1:0]         r_clr, n_clr;
    logic                  r_out_valid, n_out_valid;
    logic                  r_phase, n_phase;
    logic                  r_iss_ok, n_iss_ok;
    logic                  r_chk_valid, n_chk_valid;

    // Payload state.
    t_op                   r_op, n_op;
    logic [FB-1:0]         r_f, n_f;
    logic [AW-1:0]         r_scan_addr, n_scan_addr;
    logic [MAP_BITS-1:0]   r_lim, n_lim;
    logic                  r_iss_first, n_iss_first;
    logic                  r_chk_first, n_chk_first;
    logic [AW-1:0]         r_chk_addr, n_chk_addr;
    logic [MAP_W-1:0]      r_word, n_word;
    logic [FB-1:0]         r_target, n_target;
    logic [OUT_W-1:0]      r_out_data, n_out_data;

    // Memory ports.
    logic                  cnt_re, cnt_we;
    logic [FB-1:0]         cnt_raddr, cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_rdata, cnt_wdata;
    logic                  map_re, map_we;
    logic [AW-1:0]         map_raddr, map_waddr;
    logic [MAP_W-1:0]      map_rdata, map_wdata;

    // Search unit.
    t_find_req             find_req;
    t_find_rsp             find_rsp;

    // Helpers.
    logic                  in_acc;
    logic [FB-1:0]         in_floor;
    logic                  in_floor_ok;
    logic [PW-1:0]         pos_inc, pos_dec;
    logic [FB-1:0]         seek_floor;
    logic                  seek_none;
    logic [COUNT_BITS-1:0] upd_new;
    logic [MAP_W-1:0]      upd_word;

    esc_count_ram #(
        .DEPTH (FLOORS),
        .AW    (FB),
        .DW    (COUNT_BITS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata)
    );

    esc_map_ram #(
        .DEPTH (NW),
        .AW    (AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_re    (map_re),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata)
    );

    esc_find u_find (
        .i_req (find_req),
        .o_rsp (find_rsp)
    );

    // Ports.
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = 16'(r_out_data);

    assign in_floor    = FB'(i_s_tdata[9:0]);
    assign in_floor_ok = 32'(i_s_tdata[9:0]) < FLOORS;

    // Start of a search in the current direction, strictly beyond the current floor.
    assign pos_inc    = r_pos + PW'(1);
    assign pos_dec    = r_pos - PW'(1);
    assign seek_floor = r_up ? pos_inc[FB-1:0] : pos_dec[FB-1:0];
    assign seek_none  = r_up ? (int'(r_pos) == FLOORS - 1)
                             : (r_pos[PW-1] || (r_pos == '0));

    // Counter update for add and cancel.
    always_comb begin
        upd_new = cnt_rdata;
        if (r_op == OP_ADD) begin
            if (cnt_rdata != COUNT_MAX) begin
                upd_new = cnt_rdata + COUNT_BITS'(1);
            end
        end else if (cnt_rdata != '0) begin
            upd_new = cnt_rdata - COUNT_BITS'(1);
        end
        upd_word = map_rdata;
        upd_word[f_bit(r_f)] = (upd_new != '0);
    end

    // Search request for the word that just came out of the bitmap memory.
    always_comb begin
        find_req.word  = map_rdata;
        find_req.up    = r_up;
        find_req.first = r_chk_first;
        find_req.lim   = r_lim;
    end

    // Next state, memory commands and register updates.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_up        = r_up;
        n_nz        = r_nz;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_m_tready;
        n_phase     = r_phase;
        n_iss_ok    = r_iss_ok;
        n_chk_valid = r_chk_valid;
        n_op        = r_op;
        n_f         = r_f;
        n_scan_addr = r_scan_addr;
        n_lim       = r_lim;
        n_iss_first = r_iss_first;
        n_chk_first = r_chk_first;
        n_chk_addr  = r_chk_addr;
        n_word      = r_word;
        n_target    = r_target;
        n_out_data  = r_out_data;

        cnt_re    = 1'b0;
        cnt_raddr = in_floor;
        cnt_we    = 1'b0;
        cnt_waddr = r_f;
        cnt_wdata = upd_new;
        map_re    = 1'b0;
        map_raddr = f_word(in_floor);
        map_we    = 1'b0;
        map_waddr = f_word(r_f);
        map_wdata = upd_word;

        case (r_state)
            // Sweep both memories to zero after reset.
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                map_we    = 1'b1;
                map_waddr = f_word(r_clr);
                map_wdata = '0;
                n_clr     = r_clr + FB'(1);
                if (int'(r_clr) == FLOORS - 1) begin
                    n_state = ST_IDLE;
                end
            end

            // Take one item and dispatch on its opcode.
            ST_IDLE: begin
                if (in_acc) begin
                    n_op = t_op'(i_s_tuser);
                    n_f  = in_floor;
                    case (t_op'(i_s_tuser))
                        OP_ADD, OP_CANCEL: begin
                            if (in_floor_ok) begin
                                cnt_re  = 1'b1;
                                map_re  = 1'b1;
                                n_state = ST_UPD;
                            end
                        end
                        OP_ARRIVE: begin
                            if (r_nz != '0) begin
                                n_phase = 1'b0;
                                n_state = ST_SEEK;
                            end
                        end
                        OP_QUERY: begin
                            n_state = ST_REPORT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            // Write back the counter and its occupancy bit.
            ST_UPD: begin
                cnt_we  = 1'b1;
                map_we  = 1'b1;
                if ((cnt_rdata == '0) && (upd_new != '0)) begin
                    n_nz = r_nz + NZW'(1);
                end else if ((cnt_rdata != '0) && (upd_new == '0)) begin
                    n_nz = r_nz - NZW'(1);
                end
                n_state = ST_IDLE;
            end

            // Load the current floor once the output register is free.
            ST_REPORT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_W'(r_pos);
                    n_state     = ST_IDLE;
                end
            end

            // Set up a scan in the current direction.
            ST_SEEK: begin
                if (seek_none) begin
                    n_state = ST_MISS;
                end else begin
                    n_scan_addr = f_word(seek_floor);
                    n_lim       = f_bit(seek_floor);
                    n_iss_first = 1'b1;
                    n_iss_ok    = 1'b1;
                    n_chk_valid = 1'b0;
                    n_state     = ST_SCAN;
                end
            end

            // Read one bitmap word per cycle and check the one read before.
            ST_SCAN: begin
                map_re      = r_iss_ok;
                map_raddr   = r_scan_addr;
                n_chk_valid = r_iss_ok;
                n_chk_first = r_iss_first;
                n_chk_addr  = r_scan_addr;
                n_iss_first = 1'b0;
                if (r_up) begin
                    if (r_scan_addr == AW'(NW - 1)) begin
                        n_iss_ok = 1'b0;
                    end
                    n_scan_addr = r_scan_addr + AW'(1);
                end else begin
                    if (r_scan_addr == '0) begin
                        n_iss_ok = 1'b0;
                    end
                    n_scan_addr = r_scan_addr - AW'(1);
                end
                if (r_chk_valid) begin
                    if (find_rsp.found) begin
                        n_target  = FB'({r_chk_addr, find_rsp.bit_idx});
                        n_pos     = PW'({r_chk_addr, find_rsp.bit_idx});
                        n_word    = map_rdata;
                        cnt_re    = 1'b1;
                        cnt_raddr = FB'({r_chk_addr, find_rsp.bit_idx});
                        n_state   = ST_DEC;
                    end else if (!r_iss_ok) begin
                        n_state = ST_MISS;
                    end
                end
            end

            // Nothing beyond: reverse once, then give up with floor -1.
            ST_MISS: begin
                if (!r_phase) begin
                    n_up    = !r_up;
                    n_phase = 1'b1;
                    n_state = ST_SEEK;
                end else begin
                    n_pos   = '1;
                    n_state = ST_IDLE;
                end
            end

            // Remove one request at the chosen stop.
            ST_DEC: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_target;
                cnt_wdata = cnt_rdata - COUNT_BITS'(1);
                map_waddr = f_word(r_target);
                map_wdata = r_word;
                map_wdata[f_bit(r_target)] = 1'b0;
                if (cnt_rdata == COUNT_BITS'(1)) begin
                    map_we = 1'b1;
                    n_nz   = r_nz - NZW'(1);
                end
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pos       <= '0;
            r_up        <= 1'b1;
            r_nz        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_iss_ok    <= 1'b0;
            r_chk_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_up        <= n_up;
            r_nz        <= n_nz;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_phase     <= n_phase;
            r_iss_ok    <= n_iss_ok;
            r_chk_valid <= n_chk_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_f         <= n_f;
        r_scan_addr <= n_scan_addr;
        r_lim       <= n_lim;
        r_iss_first <= n_iss_first;
        r_chk_first <= n_chk_first;
        r_chk_addr  <= n_chk_addr;
        r_word      <= n_word;
        r_target    <= n_target;
        r_out_data  <= n_out_data;
    end

`ifndef NO_ASSERTIONS
    // A stop taken from the bitmap must have a nonzero counter behind it.
    a_dec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEC) |-> (cnt_rdata != '0))
        else $error("chosen stop has a zero request count");

    // The occupancy bit read with a counter agrees with that counter.
    a_map_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (map_rdata[f_bit(r_f)] == (cnt_rdata != '0)))
        else $error("occupancy bit disagrees with request count");

    // The number of occupied floors never exceeds the floor count.
    a_nz_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_nz) <= FLOORS)
        else $error("occupied floor count out of range");

    // The current floor is -1 or a real floor.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_pos) >= -1) && (int'(r_pos) < FLOORS))
        else $error("current floor out of range");
`endif

endmodule

// File: tb/esc_floor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_floor_checker
// Watches both streams of the SCAN stop scheduler, keeps its own copy of the
// request counts, floor and direction, and checks every floor report.
// ----------------------------------------------------------------------------
module esc_floor_checker #(
    parameter int FLOORS     = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,  // [9:0] floor, rest zero
    input  logic [1:0]  i_s_tuser,  // [1:0] opcode
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,  // [10:0] current_floor, rest zero
    output int          o_fail_count,
    output int          o_waiting,
    output int          o_reports
);
    import esc_pkg::*;

    // Shadow state of the scheduler.
    logic [COUNT_BITS-1:0] floor_count [FLOORS];
    int                    cur_floor;
    logic                  heading_up;
    int                    total_requests;

    // Floors that queries have yet to report, oldest first.
    logic [OUT_W-1:0]      due_floor_q [$];
    int                    fails;
    int                    reports;

    // Nearest requested floor strictly above the given one, or -1.
    function automatic int nearest_above(int from);
        int f;
        for (f = from + 1; f < FLOORS; f++) begin
            if (f >= 0 && floor_count[f] != '0) begin
                return f;
            end
        end
        return -1;
    endfunction

    // Nearest requested floor strictly below the given one, or -1.
    function automatic int nearest_below(int from);
        int f;
        int start;
        start = (from > FLOORS) ? FLOORS : from;
        for (f = start - 1; f >= 0; f--) begin
            if (floor_count[f] != '0) begin
                return f;
            end
        end
        return -1;
    endfunction

    task automatic clear_schedule();
        int f;
        for (f = 0; f < FLOORS; f++) begin
            floor_count[f] = '0;
        end
        cur_floor      = 0;
        heading_up     = 1'b1;
        total_requests = 0;
        due_floor_q.delete();
    endtask

    // Apply one accepted item to the shadow state.
    task automatic advance_schedule(t_op op, logic [9:0] fl);
        int target;
        case (op)
            OP_ADD: begin
                if (int'(fl) < FLOORS && floor_count[fl] != '1) begin
                    floor_count[fl] = floor_count[fl] + 1'b1;
                    total_requests++;
                end
            end
            OP_CANCEL: begin
                if (int'(fl) < FLOORS && floor_count[fl] != '0) begin
                    floor_count[fl] = floor_count[fl] - 1'b1;
                    total_requests--;
                end
            end
            OP_ARRIVE: begin
                // Nothing pending leaves floor and direction alone.
                if (total_requests != 0) begin
                    target = heading_up ? nearest_above(cur_floor) : nearest_below(cur_floor);
                    if (target < 0) begin
                        heading_up = !heading_up;
                        target = heading_up ? nearest_above(cur_floor)
                                            : nearest_below(cur_floor);
                    end
                    cur_floor = target;
                    if (target >= 0 && floor_count[target] != '0) begin
                        floor_count[target] = floor_count[target] - 1'b1;
                        total_requests--;
                    end
                end
            end
            default: begin
                due_floor_q.push_back(cur_floor[OUT_W-1:0]);
            end
        endcase
    endtask

    // Track accepted items and compare accepted reports.
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (!i_rst_n) begin
            clear_schedule();
            fails   = 0;
            reports = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                advance_schedule(t_op'(i_s_tuser), i_s_tdata[9:0]);
            end
            if (i_m_tvalid && i_m_tready) begin
                reports++;
                if (due_floor_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected report, current_floor %0d with no query open",
                             $time, $signed(i_m_tdata[OUT_W-1:0]));
                end else begin
                    want = due_floor_q.pop_front();
                    if (i_m_tdata !== {{(16 - OUT_W){1'b0}}, want}) begin
                        fails++;
                        $display("%0t: current_floor mismatch, expected %0d (0x%04h) actual %0d (0x%04h)",
                                 $time, $signed(want), {{(16 - OUT_W){1'b0}}, want},
                                 $signed(i_m_tdata[OUT_W-1:0]), i_m_tdata);
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_waiting    <= due_floor_q.size();
        o_reports    <= reports;
    end

endmodule

// File: tb/tb_elevator_scan_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevator_scan_scheduler
// Drives add, cancel, arrive and query items into the SCAN stop scheduler with
// random gaps and back-pressure; the floor checker beside it scores reports.
// ----------------------------------------------------------------------------
module tb_elevator_scan_scheduler;
    import esc_pkg::*;

    localparam int FLOORS       = 1024;
    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        steady   = 1'b0;

    int          fail_count;
    int          waiting;
    int          reports;
    int          items_sent   = 0;
    int          arrives_sent = 0;
    int          stall_cycles = 0;

    always #5 clk = ~clk;

    elevator_scan_scheduler #(
        .FLOORS     (FLOORS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    esc_floor_checker #(
        .FLOORS     (FLOORS),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_reports    (reports)
    );

    // Report side stalls about one cycle in eight unless in a steady stretch.
    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= 12);
    end

    // Watchdog on cycles where neither stream moves an item.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one item, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_item(t_op op, logic [9:0] fl);
        while (!steady && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, fl};
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        items_sent++;
        if (op == OP_ARRIVE) begin
            arrives_sent++;
        end
    endtask

    // Hold the sender off until every open query has been answered.
    task automatic wait_reports();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) begin
            @(posedge clk);
        end
    endtask

    // Hand-picked sequence over the corner cases; it ends with nothing pending.
    task automatic run_directed();
        send_item(OP_QUERY, 10'd0);
        // Arrive with nothing pending keeps floor and direction.
        send_item(OP_ARRIVE, 10'h3ff);
        send_item(OP_QUERY, 10'h3ff);
        // Only the current floor requested: direction flips, floor goes to -1.
        send_item(OP_ADD, 10'd0);
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
        // From -1 every request lies above.
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
        // Top floor twice, and a cancel that finds the count already zero.
        send_item(OP_ADD, 10'd1023);
        send_item(OP_ADD, 10'd1023);
        send_item(OP_ADD, 10'd512);
        send_item(OP_CANCEL, 10'd512);
        send_item(OP_CANCEL, 10'd512);
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
        // Reversal at the top, then a sweep down.
        send_item(OP_ADD, 10'd5);
        send_item(OP_ADD, 10'd700);
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
        send_item(OP_ARRIVE, 10'd0);
        send_item(OP_QUERY, 10'd0);
    endtask

    // Random traffic clustered around a moving window of floors, alternating
    // between filling and draining episodes.
    task automatic run_random(int count);
        int         i;
        int         base;
        int         span;
        int         pick;
        int         rnd;
        int         spot;
        bit         draining;
        t_op        op;
        logic [9:0] fl;
        base     = 0;
        span     = 1;
        draining = 1'b0;
        for (i = 0; i < count; i++) begin
            if (i % 80 == 0) begin
                case ($urandom_range(3))
                    0: base = 0;
                    1: base = FLOORS - 64;
                    default: base = $urandom_range(FLOORS - 1);
                endcase
                case ($urandom_range(3))
                    0: span = 1;
                    1: span = 4;
                    2: span = 16;
                    default: span = 64;
                endcase
                draining = ($urandom_range(2) == 0);
            end
            if (i == count / 3) begin
                steady <= 1'b1;
            end
            if (i == count / 2) begin
                steady <= 1'b0;
            end
            if (i == (count * 3) / 4) begin
                wait_reports();
            end
            pick = $urandom_range(99);
            if (draining) begin
                op = (pick < 10) ? OP_ADD : (pick < 40) ? OP_CANCEL :
                     (pick < 80) ? OP_ARRIVE : OP_QUERY;
            end else begin
                op = (pick < 40) ? OP_ADD : (pick < 55) ? OP_CANCEL :
                     (pick < 80) ? OP_ARRIVE : OP_QUERY;
            end
            rnd = $urandom();
            if ($urandom_range(99) < 15) begin
                fl = rnd[9:0];
            end else begin
                spot = (base + $urandom_range(span - 1)) % FLOORS;
                fl   = spot[9:0];
            end
            send_item(op, fl);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_ITEMS);
        wait_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items (%0d arrives) over corner cases and clustered random traffic;",
                 items_sent, arrives_sent);
        $display("checked %0d floor reports with random gaps and stalls on both streams.",
                 reports);
        if (waiting != 0) begin
            $display("%0t: %0d floor reports never arrived", $time, waiting);
        end
        if (fail_count == 0 && waiting == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
